// File: rtl/core/fhcc_pkg.sv
`default_nettype none
package fhcc_pkg;

    localparam int CNT_W = 17;

    localparam logic [CNT_W-1:0] HDR_BYTES  = 17'd12;
    localparam logic [CNT_W-1:0] SEQ_END    = 17'd6;
    localparam logic [CNT_W-1:0] LEN_END    = 17'd8;
    localparam logic [CNT_W-1:0] SYNC_END   = 17'd4;
    localparam logic [CNT_W-1:0] COUNT_SAT  = 17'd65548;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;
    localparam logic [7:0]  SYNC_EVEN = 8'hAA;
    localparam logic [7:0]  SYNC_ODD  = 8'h55;

    // queue between byte classification and crc/verdict logic
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_HDR_SHORT = 2'd1,
        VERDICT_PAY_SHORT = 2'd2,
        VERDICT_CRC_BAD   = 2'd3
    } verdict_t;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SYNC,
        KIND_SEQ,
        KIND_LEN,
        KIND_RCRC
    } byte_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
    } in_beat_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        sync_ok;
        logic [15:0] sequence_res;
        logic [15:0] payload_length;
    } out_beat_t;

    // one classified byte on its way to the back end
    typedef struct packed {
        logic [7:0] data_byte;
        byte_kind_t kind;
        logic       crc_en;
        logic       sync_bad;
        logic       last;
        logic       hdr_short;
        logic       pay_short;
        logic       have_seq;
        logic       have_len;
    } op_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/fhcc_front.sv
`default_nettype none
module fhcc_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             byte_valid,
    output logic                  byte_ready,
    input  wire fhcc_pkg::in_beat_t byte_beat,
    output logic                  op_valid,
    input  wire logic             op_ready,
    output fhcc_pkg::op_t         op
);
    import fhcc_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [15:0]      len_reg, len_next;
    logic [CNT_W-1:0] cnt_inc;
    logic [CNT_W-1:0] crc_lim;
    logic [CNT_W-1:0] pay_lim;
    logic [7:0]       sync_want;
    logic             accept;
    logic             last;

    assign byte_ready = op_ready;
    assign op_valid   = byte_valid;
    assign accept     = byte_valid && op_ready;
    assign last       = byte_beat.frame_end;

    always_comb
    begin
        sync_want = cnt_reg[0] ? SYNC_ODD : SYNC_EVEN;
        cnt_inc   = (cnt_reg < COUNT_SAT) ? (cnt_reg + 17'd1) : cnt_reg;
        len_next  = len_reg;
        op.kind   = KIND_NONE;
        if (cnt_reg < SYNC_END) begin
            op.kind = KIND_SYNC;
        end else if (cnt_reg < SEQ_END) begin
            op.kind = KIND_SEQ;
        end else if (cnt_reg < LEN_END) begin
            op.kind  = KIND_LEN;
            len_next = {len_reg[7:0], byte_beat.data_byte};
        end else if (cnt_reg < HDR_BYTES) begin
            op.kind = KIND_RCRC;
        end
        crc_lim = {1'b0, len_reg} + HDR_BYTES;
        pay_lim = {1'b0, len_next} + HDR_BYTES;

        op.data_byte = byte_beat.data_byte;
        op.sync_bad  = (cnt_reg < SYNC_END) && (byte_beat.data_byte != sync_want);
        op.crc_en    = (cnt_reg < LEN_END) ||
                       ((cnt_reg >= HDR_BYTES) && (cnt_reg < crc_lim));
        op.last      = last;
        op.hdr_short = cnt_inc < HDR_BYTES;
        op.pay_short = cnt_inc < pay_lim;
        op.have_seq  = cnt_inc >= SEQ_END;
        op.have_len  = cnt_inc >= LEN_END;

        cnt_next = cnt_reg;
        if (accept) begin
            cnt_next = last ? '0 : cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
            len_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (accept) begin
                len_reg <= last ? 16'd0 : len_next;
            end
        end
    end

    // frame end rearms the byte counter
    a_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last |=> cnt_reg == '0)
        else $error("byte counter not cleared after frame end");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= COUNT_SAT)
        else $error("byte counter past saturation");

endmodule
`default_nettype wire

// File: rtl/core/fhcc_queue.sv
`default_nettype none
module fhcc_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire fhcc_pkg::op_t push_op,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output fhcc_pkg::op_t      pop_op
);
    import fhcc_pkg::*;

    op_t                    mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_reg, wr_next;
    logic [QUEUE_PTR_W-1:0] rd_reg, rd_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic                   push, pop;

    assign push_ready = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_op     = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_next = wr_reg;
        rd_next = rd_reg;
        if (push) begin
            wr_next = (wr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        count_next = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_reg] <= push_op;
        end
    end

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy out of range");

endmodule
`default_nettype wire

// File: rtl/core/fhcc_back.sv
`default_nettype none
module fhcc_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          op_valid,
    output logic               op_ready,
    input  wire fhcc_pkg::op_t op,
    output logic               result_valid,
    input  wire logic          result_ready,
    output fhcc_pkg::out_beat_t result_beat
);
    import fhcc_pkg::*;

    logic [31:0] crc_reg, crc_next;
    logic [31:0] rcrc_reg, rcrc_next;
    logic [15:0] seq_reg, seq_next;
    logic [15:0] len_reg, len_next;
    logic        sync_reg, sync_next;
    logic        out_valid_reg;
    out_beat_t   out_reg, out_next;
    logic        pop;

    assign op_ready     = !op.last || !out_valid_reg || result_ready;
    assign pop          = op_valid && op_ready;
    assign result_valid = out_valid_reg;
    assign result_beat  = out_reg;

    always_comb
    begin
        sync_next = sync_reg && !op.sync_bad;
        seq_next  = (op.kind == KIND_SEQ)  ? {seq_reg[7:0], op.data_byte}   : seq_reg;
        len_next  = (op.kind == KIND_LEN)  ? {len_reg[7:0], op.data_byte}   : len_reg;
        rcrc_next = (op.kind == KIND_RCRC) ? {rcrc_reg[23:0], op.data_byte} : rcrc_reg;
        crc_next  = op.crc_en ? crc_byte(crc_reg, op.data_byte) : crc_reg;

        if (op.hdr_short) begin
            out_next.verdict = VERDICT_HDR_SHORT;
        end else if (op.pay_short) begin
            out_next.verdict = VERDICT_PAY_SHORT;
        end else if ((crc_next ^ CRC_ONES) != rcrc_next) begin
            out_next.verdict = VERDICT_CRC_BAD;
        end else begin
            out_next.verdict = VERDICT_OK;
        end
        out_next.sync_ok        = !op.hdr_short && sync_next;
        out_next.sequence_res   = op.have_seq ? seq_next : 16'd0;
        out_next.payload_length = op.have_len ? len_next : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg       <= CRC_ONES;
            rcrc_reg      <= '0;
            seq_reg       <= '0;
            len_reg       <= '0;
            sync_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                if (op.last) begin
                    crc_reg  <= CRC_ONES;
                    rcrc_reg <= '0;
                    seq_reg  <= '0;
                    len_reg  <= '0;
                    sync_reg <= 1'b1;
                end else begin
                    crc_reg  <= crc_next;
                    rcrc_reg <= rcrc_next;
                    seq_reg  <= seq_next;
                    len_reg  <= len_next;
                    sync_reg <= sync_next;
                end
            end
            if (pop && op.last) begin
                out_valid_reg <= 1'b1;
            end else if (result_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && op.last) begin
            out_reg <= out_next;
        end
    end

    a_crc_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        pop && op.last |=> crc_reg == CRC_ONES && sync_reg)
        else $error("crc state not rearmed after frame end");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result_ready |-> !(pop && op.last))
        else $error("verdict overwritten before it was taken");

endmodule
`default_nettype wire

// File: rtl/core/frame_header_crc_checker.sv
`default_nettype none
// a final beat is written into the queue, popped by the back end and its verdict
// captured in the output register, which drives result_valid
// throughput: one byte per cycle, sustained across frames while verdict beats are taken
// the rate is set by the byte-wide crc-32 update in the back end, one byte a cycle
// reset: byte counter, length and crc state cleared (crc to all ones), queue
// emptied, no verdict pending; byte_ready is high again as soon as reset is released
module frame_header_crc_checker (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // received frame bytes
    input  wire logic                 byte_valid,
    output logic                      byte_ready,
    input  wire fhcc_pkg::in_beat_t   byte_beat,
    // one verdict beat per frame
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output fhcc_pkg::out_beat_t       result_beat
);
    import fhcc_pkg::*;

    // classified byte from front end into the queue
    logic front_valid, front_ready;
    op_t  front_op;
    // queue head into the crc and verdict back end
    logic back_valid, back_ready;
    op_t  back_op;

    // front end: counts bytes, captures the payload length, tags each byte
    // with its header role, crc coverage and the end-of-frame size checks
    fhcc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_beat  (byte_beat),
        .op_valid   (front_valid),
        .op_ready   (front_ready),
        .op         (front_op)
    );

    // short queue so a stalled verdict does not stop byte intake at once
    fhcc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    // back end: running crc, header field capture, verdict into an output register
    fhcc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (back_valid),
        .op_ready     (back_ready),
        .op           (back_op),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

endmodule
`default_nettype wire
